[rtl/hcm_pkg.sv]
// ----------------------------------------------------------------------------
// hcm_pkg: shared types and constants of the heatmap color mapper
// Field widths, register codes, reset values and the per-word tag that rides
// the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package hcm_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int INDEX_W    = 10;
    localparam int CHAN_W     = 16;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = COLOR_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select is paddr[2]
    localparam logic REG_RANGE_MIN = 1'b0;
    localparam logic REG_RANGE_MAX = 1'b1;

    localparam logic [VALUE_W-1:0] RANGE_MIN_RST = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] RANGE_MAX_RST = 32'h0001_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    typedef struct packed {
        logic               is_map;
        logic               low;
        logic               high;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] color;
    } tag_t;

endpackage

[rtl/heatmap_color_mapper.sv]
// ----------------------------------------------------------------------------
// heatmap_color_mapper: scalar sample to RGB through a color table
// Normalizes a Q16.16 sample against range_min/range_max, then blends two
// adjacent table entries per channel; load words write table entries.
//
//   port group   dir   width   contents
//   s_axis       in    96+1    load word or sample word, op in tuser
//   m_axis       out   48      interpolated color, one per sample word
//   apb          in    32      range_min at 0x0, range_max at 0x4
//
// One word per cycle, loads and samples alike, while the pipeline is not frozen.
// AW = log2 of the table depth: the restoring divider retires one quotient
// bit per stage over AW + 16 stages.
// The table is undefined after reset and needs no clearing; config regs
// reset to 0.0 and 1.0. The pipeline freezes only when a result reaches the
// last stage while the output register still holds an untaken word.
// ----------------------------------------------------------------------------
module heatmap_color_mapper #(
    parameter int TABLE_ENTRIES = hcm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] entry_index, [25:10] entry_red, [41:26] entry_green,
    // [57:42] entry_blue, [89:58] sample, [95:90] zero
    input  logic [hcm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                           s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    output logic [hcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hcm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hcm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int QW    = AW + hcm_pkg::FRAC_W;
    localparam int VW    = hcm_pkg::VALUE_W;
    localparam int DW    = VW + 1;
    localparam int PW    = VW + AW;
    localparam int CW    = hcm_pkg::CHAN_W;
    localparam int BW    = CW + 1;
    localparam int MW    = 2 * BW;
    localparam int NCH   = 3;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
    localparam logic signed [DW-1:0] ONE_Q = DW'(1 << hcm_pkg::FRAC_W);
    localparam logic signed [MW-1:0] HALF  = MW'(1 << (hcm_pkg::FRAC_W - 1));

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [VW-1:0] range_min_reg;
    logic [VW-1:0] range_max_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= hcm_pkg::RANGE_MIN_RST;
            range_max_reg <= hcm_pkg::RANGE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                hcm_pkg::REG_RANGE_MIN: range_min_reg <= pwdata;
                hcm_pkg::REG_RANGE_MAX: range_max_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            hcm_pkg::REG_RANGE_MIN: prdata = range_min_reg;
            hcm_pkg::REG_RANGE_MAX: prdata = range_max_reg;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    logic                 adv;
    logic                 in_acc;
    hcm_pkg::tag_t        in_tag;

    logic                 s1_vld_reg;
    hcm_pkg::tag_t        s1_tag_reg;
    logic signed [DW-1:0] s1_diff_reg;
    logic signed [DW-1:0] s1_span_reg;

    logic                 s2_vld_reg;
    hcm_pkg::tag_t        s2_tag_reg;
    logic [VW-1:0]        s2_ud_reg;
    logic [VW-1:0]        s2_us_reg;

    // divider stages: index 0 is the multiplier output, QW is the read stage
    logic                 dv_vld_reg [QW+1];
    hcm_pkg::tag_t        dv_tag_reg [QW+1];
    logic [VW-1:0]        dv_rem_reg [QW+1];
    logic [QW-1:0]        dv_nq_reg  [QW+1];
    logic [VW-1:0]        dv_us_reg  [QW+1];

    logic                 d_vld_reg;
    logic                 d_map_reg;
    logic [CW-1:0]        d_frac_reg;

    logic                 p_vld_reg;
    logic                 p_map_reg;
    logic [hcm_pkg::COLOR_W-1:0] p_base_reg;
    logic signed [MW-1:0] p_prod_reg [NCH];

    logic                 out_vld_reg;
    logic [hcm_pkg::OUT_DATA_W-1:0] out_data_reg;

    // stall only when a result would collide with a held output word
    assign adv = !(p_vld_reg && p_map_reg && out_vld_reg && !m_axis_tready);
    assign s_axis_tready = adv;
    assign in_acc = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        in_tag        = '0;
        in_tag.is_map = (s_axis_tuser == hcm_pkg::OP_MAP);
        in_tag.idx    = s_axis_tdata[9:0];
        in_tag.color  = s_axis_tdata[57:10];
    end

    // ------------------------------------------------------------------
    // stage 2 comb: span fixup, clamps, magnitudes
    // ------------------------------------------------------------------
    logic signed [DW-1:0] s1_span_eff;
    logic                 s1_neg;
    logic                 s1_low;
    logic                 s1_high;
    logic signed [DW-1:0] s1_diff_abs;
    logic signed [DW-1:0] s1_span_abs;
    hcm_pkg::tag_t        s2_tag_next;

    always_comb
    begin
        s1_span_eff = (s1_span_reg == '0) ? ONE_Q : s1_span_reg;
        s1_neg      = s1_span_eff[DW-1];
        // negative span flips the ratio's sign, so the comparisons flip too
        s1_low      = s1_neg ? (s1_diff_reg >= 0) : (s1_diff_reg <= 0);
        s1_high     = s1_neg ? (s1_diff_reg <= s1_span_eff)
                             : (s1_diff_reg >= s1_span_eff);
        s1_diff_abs = s1_neg ? -s1_diff_reg : s1_diff_reg;
        s1_span_abs = s1_neg ? -s1_span_eff : s1_span_eff;
        s2_tag_next      = s1_tag_reg;
        s2_tag_next.low  = s1_low;
        s2_tag_next.high = s1_high;
    end

    // multiplier: ud * (entries - 1), then seed the divider
    logic [PW-1:0] s2_prod;
    assign s2_prod = PW'(s2_ud_reg) * PW'(LAST);

    // ------------------------------------------------------------------
    // divider comb: one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DW-1:0] dv_trial [QW];
    logic [DW-1:0] dv_sub   [QW];
    logic          dv_ge    [QW];
    logic [VW-1:0] dv_rem_next [QW];
    logic [QW-1:0] dv_nq_next  [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            dv_trial[k]    = {dv_rem_reg[k], dv_nq_reg[k][QW-1]};
            dv_sub[k]      = dv_trial[k] - {1'b0, dv_us_reg[k]};
            dv_ge[k]       = dv_trial[k] >= {1'b0, dv_us_reg[k]};
            dv_rem_next[k] = dv_ge[k] ? dv_sub[k][VW-1:0] : dv_trial[k][VW-1:0];
            dv_nq_next[k]  = {dv_nq_reg[k][QW-2:0], dv_ge[k]};
        end
    end

    // ------------------------------------------------------------------
    // read stage: table addresses, fraction, table writes
    // ------------------------------------------------------------------
    hcm_pkg::tag_t r_tag;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [CW-1:0] r_frac;
    logic          r_wr;

    assign r_tag = dv_tag_reg[QW];
    assign r_idx = dv_nq_reg[QW][QW-1:hcm_pkg::FRAC_W];

    always_comb
    begin
        r_addr_a = r_idx;
        r_addr_b = r_idx + AW'(1);
        r_frac   = dv_nq_reg[QW][hcm_pkg::FRAC_W-1:0];
        if (r_tag.low)
        begin
            r_addr_a = '0;
            r_addr_b = '0;
            r_frac   = '0;
        end
        else if (r_tag.high || r_idx >= LAST)
        begin
            r_addr_a = LAST;
            r_addr_b = LAST;
            r_frac   = '0;
        end
    end

    // loads write in pipeline order, so earlier samples see the old entry
    assign r_wr = adv && dv_vld_reg[QW] && !r_tag.is_map
               && (32'(r_tag.idx) < 32'(TABLE_ENTRIES));

    logic [hcm_pkg::COLOR_W-1:0] rd_a;
    logic [hcm_pkg::COLOR_W-1:0] rd_b;

    hcm_ram #(
        .WIDTH (hcm_pkg::COLOR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram_lo (
        .clk     (clk),
        .wr_en   (r_wr),
        .wr_addr (AW'(r_tag.idx)),
        .wr_data (r_tag.color),
        .rd_en   (adv),
        .rd_addr (r_addr_a),
        .rd_data (rd_a)
    );

    // second copy of the table for the upper neighbor
    hcm_ram #(
        .WIDTH (hcm_pkg::COLOR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram_hi (
        .clk     (clk),
        .wr_en   (r_wr),
        .wr_addr (AW'(r_tag.idx)),
        .wr_data (r_tag.color),
        .rd_en   (adv),
        .rd_addr (r_addr_b),
        .rd_data (rd_b)
    );

    // ------------------------------------------------------------------
    // blend: a + round((b - a) * f / 2^16)
    // ------------------------------------------------------------------
    logic signed [BW-1:0] d_delta  [NCH];
    logic signed [BW-1:0] d_frac_s;
    logic signed [MW-1:0] d_prod   [NCH];
    logic signed [MW-1:0] p_rnd    [NCH];
    logic signed [MW-1:0] p_sh     [NCH];
    logic [hcm_pkg::OUT_DATA_W-1:0] p_color;

    always_comb
    begin
        d_frac_s = $signed({1'b0, d_frac_reg});
        for (int c = 0; c < NCH; c++)
        begin
            d_delta[c] = $signed({1'b0, rd_b[c*CW +: CW]})
                       - $signed({1'b0, rd_a[c*CW +: CW]});
            d_prod[c]  = MW'(d_delta[c]) * MW'(d_frac_s);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            p_rnd[c] = p_prod_reg[c] + HALF;
            p_sh[c]  = p_rnd[c] >>> hcm_pkg::FRAC_W;
            p_color[c*CW +: CW] = p_base_reg[c*CW +: CW] + p_sh[c][CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // valid bits and output handshake
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv)
            begin
                s1_vld_reg    <= in_acc;
                s2_vld_reg    <= s1_vld_reg;
                dv_vld_reg[0] <= s2_vld_reg;
                for (int k = 0; k < QW; k++)
                begin
                    dv_vld_reg[k+1] <= dv_vld_reg[k];
                end
                d_vld_reg <= dv_vld_reg[QW];
                p_vld_reg <= d_vld_reg;
            end
            if (adv && p_vld_reg && p_map_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg  <= in_tag;
            s1_diff_reg <= $signed({s_axis_tdata[89], s_axis_tdata[89:58]})
                         - $signed({range_min_reg[VW-1], range_min_reg});
            s1_span_reg <= $signed({range_max_reg[VW-1], range_max_reg})
                         - $signed({range_min_reg[VW-1], range_min_reg});

            s2_tag_reg <= s2_tag_next;
            s2_ud_reg  <= s1_diff_abs[VW-1:0];
            s2_us_reg  <= s1_span_abs[VW-1:0];

            dv_tag_reg[0] <= s2_tag_reg;
            dv_rem_reg[0] <= s2_prod[PW-1:AW];
            dv_nq_reg[0]  <= {s2_prod[AW-1:0], hcm_pkg::FRAC_W'(0)};
            dv_us_reg[0]  <= s2_us_reg;
            for (int k = 0; k < QW; k++)
            begin
                dv_tag_reg[k+1] <= dv_tag_reg[k];
                dv_rem_reg[k+1] <= dv_rem_next[k];
                dv_nq_reg[k+1]  <= dv_nq_next[k];
                dv_us_reg[k+1]  <= dv_us_reg[k];
            end

            d_map_reg  <= r_tag.is_map;
            d_frac_reg <= r_frac;

            p_map_reg  <= d_map_reg;
            p_base_reg <= rd_a;
            for (int c = 0; c < NCH; c++)
            begin
                p_prod_reg[c] <= d_prod[c];
            end
        end
        if (adv && p_vld_reg && p_map_reg)
        begin
            out_data_reg <= p_color;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/hcm_ram.sv]
// ----------------------------------------------------------------------------
// hcm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hcm_ram #(
    parameter int WIDTH = hcm_pkg::COLOR_W,
    parameter int DEPTH = hcm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[dv/heatmap_color_mapper_checker.sv]
// ----------------------------------------------------------------------------
// heatmap_color_mapper_checker: color prediction and result compare
// Watches the input stream, the output stream and the APB register writes.
// Keeps its own copy of the color table and the range registers, works out
// the color of every sample word and checks each output word against the
// oldest color still owed.
// ----------------------------------------------------------------------------
module heatmap_color_mapper_checker
    import hcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,

    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // red sits in the low bits, as on m_axis_tdata
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    localparam int LAST       = TABLE_ENTRIES - 1;
    localparam int COLOR_LSB  = INDEX_W;
    localparam int SAMPLE_LSB = INDEX_W + COLOR_W;
    localparam int MAX_REPORT = 50;

    rgb_t                      palette [TABLE_ENTRIES];
    logic signed [VALUE_W-1:0] lo_bound = RANGE_MIN_RST;
    logic signed [VALUE_W-1:0] hi_bound = RANGE_MAX_RST;
    rgb_t                      color_queue [$];

    initial errors = 0;
    initial pending = 0;

    function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                 logic [FRAC_W-1:0] f);
        longint unsigned acc;
        acc = longint'(a) * (65536 - f) + longint'(b) * f + 32768;
        return CHAN_W'(acc >> FRAC_W);
    endfunction

    function automatic rgb_t colorize(logic signed [VALUE_W-1:0] smp);
        longint            diff;
        longint            span;
        longint unsigned   ud;
        longint unsigned   us;
        longint unsigned   scaled;
        int                idx;
        logic [FRAC_W-1:0] frac;
        rgb_t              c;
        diff = longint'(smp) - longint'(lo_bound);
        span = longint'(hi_bound) - longint'(lo_bound);
        if (span == 0)
            span = 65536;
        // inverted range: flip both so the compares below stay exact
        if (span < 0)
        begin
            span = -span;
            diff = -diff;
        end
        if (diff <= 0)
            return palette[0];
        if (diff >= span)
            return palette[LAST];
        ud = diff;
        us = span;
        scaled = (ud * LAST * 65536) / us;
        idx = int'(scaled >> FRAC_W);
        frac = scaled[FRAC_W-1:0];
        if (idx >= LAST)
            return palette[LAST];
        c.red   = blend(palette[idx].red,   palette[idx+1].red,   frac);
        c.green = blend(palette[idx].green, palette[idx+1].green, frac);
        c.blue  = blend(palette[idx].blue,  palette[idx+1].blue,  frac);
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t got;
        rgb_t want;
        logic [INDEX_W-1:0] idx;
        if (!rst_n)
        begin
            lo_bound = RANGE_MIN_RST;
            hi_bound = RANGE_MAX_RST;
            color_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_RANGE_MAX)
                    hi_bound = pwdata;
                else
                    lo_bound = pwdata;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (color_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORT)
                        $display("%0t: color word %h with no sample outstanding", $time, got);
                end
                else
                begin
                    want = color_queue.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORT)
                        begin
                            if (got.red != want.red)
                                $display("%0t: red expected %h actual %h",
                                         $time, want.red, got.red);
                            if (got.green != want.green)
                                $display("%0t: green expected %h actual %h",
                                         $time, want.green, got.green);
                            if (got.blue != want.blue)
                                $display("%0t: blue expected %h actual %h",
                                         $time, want.blue, got.blue);
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_LOAD)
                begin
                    idx = s_axis_tdata[INDEX_W-1:0];
                    if (idx < TABLE_ENTRIES)
                        palette[idx] = s_axis_tdata[COLOR_LSB +: COLOR_W];
                end
                else
                    color_queue.push_back(colorize(s_axis_tdata[SAMPLE_LSB +: VALUE_W]));
            end
        end
        pending = color_queue.size();
    end

endmodule

[dv/heatmap_color_mapper_tb.sv]
// ----------------------------------------------------------------------------
// heatmap_color_mapper_tb: stimulus and verdict for the heatmap color mapper
// Loads table entries and streams samples through the block across several
// range settings (full scale, zero span, inverted, small span), with random
// gaps on the input, random stalls on the output and one long output stall.
// Every sample only touches entries that were loaded first.
// ----------------------------------------------------------------------------
module heatmap_color_mapper_tb
    import hcm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int LAST          = TABLE_ENTRIES - 1;
    localparam int PAD_W         = IN_DATA_W - VALUE_W - COLOR_W - INDEX_W;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                        mismatches;
    int                        awaiting;
    bit                        loaded [TABLE_ENTRIES];
    logic signed [VALUE_W-1:0] cur_min    = RANGE_MIN_RST;
    logic signed [VALUE_W-1:0] cur_max    = RANGE_MAX_RST;
    int                        gap_odds   = 0;
    int                        stall_odds = 0;
    bit                        squeeze    = 1'b0;

    heatmap_color_mapper #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    heatmap_color_mapper_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (mismatches),
        .pending       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // table entries a sample reads under the current range
    function automatic void entries_read(logic signed [VALUE_W-1:0] smp,
                                         output int lo, output int hi);
        longint          diff;
        longint          span;
        longint unsigned ud;
        longint unsigned us;
        longint unsigned q;
        lo = 0;
        hi = 0;
        diff = longint'(smp) - longint'(cur_min);
        span = longint'(cur_max) - longint'(cur_min);
        if (span == 0)
            span = 65536;
        if (span < 0)
        begin
            span = -span;
            diff = -diff;
        end
        if (diff <= 0)
            return;
        lo = LAST;
        hi = LAST;
        if (diff >= span)
            return;
        ud = diff;
        us = span;
        q = (ud * LAST * 65536) / us;
        if ((q >> FRAC_W) < LAST)
        begin
            lo = int'(q >> FRAC_W);
            hi = lo + 1;
        end
    endfunction

    function automatic logic [COLOR_W-1:0] random_color();
        logic [COLOR_W-1:0] c;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 5))
                0:       c[k*CHAN_W +: CHAN_W] = '0;
                1:       c[k*CHAN_W +: CHAN_W] = '1;
                default: c[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
            endcase
        end
        return c;
    endfunction

    function automatic logic [VALUE_W-1:0] random_sample();
        longint a;
        longint b;
        longint off;
        int     nudge;
        a = (cur_min < cur_max) ? cur_min : cur_max;
        b = (cur_min < cur_max) ? cur_max : cur_min;
        if (a == b)
            b = a + 65536;
        nudge = $urandom_range(0, 6);
        nudge -= 3;
        off = $urandom;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return VALUE_W'(longint'(cur_min) + nudge);
            2:       return VALUE_W'(longint'(cur_max) + nudge);
            default: return VALUE_W'(a + off % (b - a + 1));
        endcase
    endfunction

    task automatic send_word(logic op, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] rgb,
                             logic [VALUE_W-1:0] smp);
        if ($urandom_range(0, 99) < gap_odds)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{PAD_W{1'b0}}, smp, rgb, idx};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic load_entry(int idx, logic [COLOR_W-1:0] rgb);
        send_word(OP_LOAD, INDEX_W'(idx), rgb, $urandom);
        loaded[idx] = 1'b1;
    endtask

    // loads whatever the sample is about to read, then sends the sample word
    task automatic map_sample(logic [VALUE_W-1:0] smp);
        int lo;
        int hi;
        entries_read(smp, lo, hi);
        if (!loaded[lo])
            load_entry(lo, random_color());
        if (!loaded[hi])
            load_entry(hi, random_color());
        send_word(OP_MAP, INDEX_W'($urandom), random_color(), smp);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        // load words still in flight produce nothing to wait on
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic signed [VALUE_W-1:0] lo_val, logic signed [VALUE_W-1:0] hi_val,
                             int words, int gaps, int stalls, int hold_at);
        int idx;
        settle();
        write_reg(REG_RANGE_MIN, lo_val);
        write_reg(REG_RANGE_MAX, hi_val);
        cur_min = lo_val;
        cur_max = hi_val;
        gap_odds = gaps;
        stall_odds = stalls;
        map_sample(cur_min);
        map_sample(cur_max);
        map_sample(cur_min - 1);
        map_sample(cur_max + 1);
        for (int n = 0; n < words; n++)
        begin
            if (n == hold_at)
                squeeze = 1'b1;
            if ($urandom_range(0, 99) < 30)
            begin
                case ($urandom_range(0, 9))
                    0:       idx = 0;
                    1:       idx = LAST;
                    default: idx = $urandom_range(0, LAST);
                endcase
                load_entry(idx, random_color());
            end
            else
                map_sample(random_sample());
        end
    endtask

    // output side: random stalls plus one long hold-off on request
    initial
    begin : sink
        int  hold;
        bit  squeezed;
        hold = 0;
        squeezed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                hold = LONG_HOLD;
            end
            else if ($urandom_range(0, 99) < stall_odds)
                hold = $urandom_range(1, 10);
            m_axis_tready <= (hold == 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("heatmap_color_mapper test failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_odds = 20;
        stall_odds = 20;

        // reset range 0.0 .. 1.0: corner samples and rounding
        load_entry(0, '0);
        load_entry(LAST, '1);
        load_entry(1, {16'h8000, 16'hFFFF, 16'h0001});
        load_entry(511, '0);
        load_entry(512, {3{16'h0001}});
        load_entry(LAST - 1, {16'hFFFF, 16'h0000, 16'h1234});
        map_sample(32'h0000_0000);
        map_sample(32'hFFFF_FFFF);
        map_sample(32'h8000_0000);
        map_sample(32'h7FFF_FFFF);
        map_sample(32'h0001_0000);
        map_sample(32'h0001_0001);
        map_sample(32'h0000_0001);
        map_sample(32'h0000_FFFF);
        map_sample(32'h0000_8000);     // half-way blend, rounds up
        map_sample(32'h0000_0010);
        load_entry(0, random_color()); // overwrite, then read it back
        map_sample(32'h0000_0000);

        run_phase(32'sh8000_0000, 32'sh7FFF_FFFF, 50, 15, 15, 30);
        run_phase(7 << 16, 7 << 16, 50, 30, 30, -1);
        run_phase(32'sh7FFF_FFFF, 32'sh8000_0000, 50, 0, 0, -1);
        run_phase(100 << 16, -(3 << 16), 50, 40, 10, -1);
        run_phase($urandom, $urandom, 50, 10, 40, -1);
        run_phase(-5, 1018, 50, 20, 20, -1);
        run_phase(-(1 << 16), 1 << 16, 50, 0, 0, -1);
        settle();

        if (mismatches == 0 && awaiting == 0)
            $display("heatmap_color_mapper test passed");
        else
            $display("heatmap_color_mapper test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/hcm_pkg.sv
rtl/hcm_ram.sv
rtl/heatmap_color_mapper.sv
dv/heatmap_color_mapper_checker.sv
dv/heatmap_color_mapper_tb.sv
